// ===== rtl/pptcb_pkg.sv =====
package pptcb_pkg;

  // Default sizes of the store
  localparam int unsigned MaxRecordsDef = 16;
  localparam int unsigned MaxBytesDef   = 8;

  // Field widths
  localparam int unsigned WordW    = 32;
  localparam int unsigned SizeW    = 4;
  localparam int unsigned DataW    = 64;
  localparam int unsigned CntOutW  = 5;
  localparam int unsigned WinW     = 10;  // holds pre + 1 + post without wrap
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned STdataW  = 168;
  localparam int unsigned MTdataW  = 176;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgPreCount  = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgPostCount = 8'd1;

  typedef enum logic [1:0] {
    CMD_ARM  = 2'd0,
    CMD_PUSH = 2'd1,
    CMD_TRIG = 2'd2,
    CMD_POP  = 2'd3
  } cmd_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic exec;  // execute the accepted command
    logic load;  // move the pending result into the output register
  } ctl_t;

endpackage

// ===== rtl/pptcb_ctrl.sv =====
module pptcb_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output pptcb_pkg::ctl_t ctl_o
);
  import pptcb_pkg::*;

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;

  // State and output-valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.exec = 1'b1;
          state_d    = S_READ;
        end
      end
      S_READ: begin
        // result waits here while the output register is still full
        if (!out_vld_q || out_ready_i) begin
          ctl_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (ctl_o.load) out_vld_d = 1'b1;
    else if (out_ready_i) out_vld_d = 1'b0;
    else out_vld_d = out_vld_q;
  end

  assign out_valid_o = out_vld_q;

  a_read_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ && out_vld_q && !out_ready_i) |=> state_q == S_READ)
    else $error("pending result dropped while output register full");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.load |=> out_vld_q)
    else $error("loaded result not presented");

endmodule

// ===== rtl/pptcb_dp.sv =====
module pptcb_dp #(
  parameter int unsigned MAX_RECORDS = pptcb_pkg::MaxRecordsDef,
  parameter int unsigned MAX_BYTES   = pptcb_pkg::MaxBytesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pptcb_pkg::ctl_t               ctl_i,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [pptcb_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [pptcb_pkg::CfgDataW-1:0] cfg_data_i,
  // command fields
  input  pptcb_pkg::cmd_e               cmd_i,
  input  logic [pptcb_pkg::WordW-1:0]   seq_in_i,
  input  logic [pptcb_pkg::WordW-1:0]   epoch_in_i,
  input  logic [pptcb_pkg::WordW-1:0]   status_in_i,
  input  logic [pptcb_pkg::SizeW-1:0]   size_in_i,
  input  logic [pptcb_pkg::DataW-1:0]   data_in_i,
  input  logic                          terminal_i,
  // result fields
  output logic                          ok_o,
  output logic [pptcb_pkg::WordW-1:0]   rec_seq_o,
  output logic [pptcb_pkg::WordW-1:0]   rec_epoch_o,
  output logic [pptcb_pkg::WordW-1:0]   rec_status_o,
  output logic [pptcb_pkg::SizeW-1:0]   rec_size_o,
  output logic [pptcb_pkg::DataW-1:0]   rec_data_o,
  output logic                          is_ready_o,
  output logic [pptcb_pkg::CntOutW-1:0] held_count_o
);
  import pptcb_pkg::*;

  localparam int unsigned AW   = $clog2(MAX_RECORDS);
  localparam int unsigned CntW = $clog2(MAX_RECORDS + 1);

  // Configuration registers
  logic [CfgDataW-1:0] pre_cfg_q, post_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_cfg_q  <= '0;
      post_cfg_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CfgPreCount)  pre_cfg_q  <= cfg_data_i;
      if (cfg_index_i == CfgPostCount) post_cfg_q <= cfg_data_i;
    end
  end

  // Capture window state
  logic [AW-1:0]       head_q, head_d;
  logic [CntW-1:0]     fill_q, fill_d;
  logic [CfgDataW-1:0] pre_q, pre_d;
  logic [CntW-1:0]     cap_q, cap_d;
  logic [CfgDataW-1:0] post_q, post_d;
  logic                arm_q, arm_d, trg_q, trg_d, rdy_q, rdy_d;

  logic                ok;
  logic                wr_en, rd_en, clr_vld;
  logic [WinW-1:0]     arm_sum, retain;
  logic                full;
  logic [CntW:0]       slot_sum;
  logic [AW-1:0]       slot, head_inc;
  logic [MAX_BYTES-1:0] be;

  assign arm_sum  = WinW'(pre_cfg_q) + WinW'(1) + WinW'(post_cfg_q);
  assign retain   = trg_q ? WinW'(cap_q) : WinW'(pre_q) + WinW'(1);
  assign full     = WinW'(fill_q) >= retain;
  assign slot_sum = (CntW+1)'(head_q) + (CntW+1)'(fill_q);
  assign slot     = (slot_sum >= (CntW+1)'(MAX_RECORDS))
                    ? AW'(slot_sum - (CntW+1)'(MAX_RECORDS)) : AW'(slot_sum);
  assign head_inc = (head_q == AW'(MAX_RECORDS - 1)) ? '0 : head_q + AW'(1);

  // byte enables: only the first size_in bytes of the slot are written
  for (genvar b = 0; b < MAX_BYTES; b++) begin : g_be
    assign be[b] = SizeW'(b) < size_in_i;
  end

  // Command execution
  always_comb begin
    head_d  = head_q;
    fill_d  = fill_q;
    pre_d   = pre_q;
    cap_d   = cap_q;
    post_d  = post_q;
    arm_d   = arm_q;
    trg_d   = trg_q;
    rdy_d   = rdy_q;
    ok      = 1'b1;
    wr_en   = 1'b0;
    rd_en   = 1'b0;
    clr_vld = 1'b0;
    if (ctl_i.exec) begin
      unique case (cmd_i)
        CMD_ARM: begin
          if (arm_sum > WinW'(MAX_RECORDS)) begin
            ok = 1'b0;
          end else begin
            head_d  = '0;
            fill_d  = '0;
            pre_d   = pre_cfg_q;
            cap_d   = CntW'(arm_sum);
            post_d  = post_cfg_q;
            arm_d   = 1'b1;
            trg_d   = 1'b0;
            rdy_d   = 1'b0;
            clr_vld = 1'b1;
          end
        end
        CMD_PUSH: begin
          if (!arm_q || rdy_q || size_in_i > SizeW'(MAX_BYTES)) begin
            ok = 1'b0;
          end else if (full && (trg_q || fill_q == '0)) begin
            ok = 1'b0;
          end else begin
            wr_en = 1'b1;
            // before the trigger a full window drops its oldest record
            if (full) head_d = head_inc;
            else fill_d = fill_q + CntW'(1);
            if (trg_q && post_q != '0) begin
              post_d = post_q - CfgDataW'(1);
              if (post_q == CfgDataW'(1)) rdy_d = 1'b1;
            end
          end
        end
        CMD_TRIG: begin
          if (arm_q && !trg_q) begin
            trg_d = 1'b1;
            if (terminal_i || post_q == '0) rdy_d = 1'b1;
          end
        end
        CMD_POP: begin
          if (!rdy_q || fill_q == '0) begin
            ok = 1'b0;
          end else begin
            rd_en  = 1'b1;
            head_d = head_inc;
            fill_d = fill_q - CntW'(1);
            if (fill_q == CntW'(1)) begin
              arm_d = 1'b0;
              trg_d = 1'b0;
              rdy_d = 1'b0;
            end
          end
        end
        default: ok = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
      pre_q  <= '0;
      cap_q  <= '0;
      post_q <= '0;
      arm_q  <= 1'b0;
      trg_q  <= 1'b0;
      rdy_q  <= 1'b0;
    end else begin
      head_q <= head_d;
      fill_q <= fill_d;
      pre_q  <= pre_d;
      cap_q  <= cap_d;
      post_q <= post_d;
      arm_q  <= arm_d;
      trg_q  <= trg_d;
      rdy_q  <= rdy_d;
    end
  end

  // Byte valid bits: a byte not written since arm reads as zero
  logic [MAX_BYTES-1:0] bvld_q [MAX_RECORDS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_RECORDS; i++) bvld_q[i] <= '0;
    end else if (clr_vld) begin
      for (int i = 0; i < MAX_RECORDS; i++) bvld_q[i] <= '0;
    end else if (wr_en) begin
      bvld_q[slot] <= bvld_q[slot] | be;
    end
  end

  // Record store
  logic [WordW-1:0]                 seq_mem    [MAX_RECORDS];
  logic [WordW-1:0]                 epoch_mem  [MAX_RECORDS];
  logic [WordW-1:0]                 status_mem [MAX_RECORDS];
  logic [SizeW-1:0]                 size_mem   [MAX_RECORDS];
  logic [MAX_BYTES-1:0][7:0]        data_mem   [MAX_RECORDS];

  logic [WordW-1:0]          rd_seq_q, rd_epoch_q, rd_status_q;
  logic [SizeW-1:0]          rd_size_q;
  logic [MAX_BYTES-1:0][7:0] rd_data_q;
  logic [MAX_BYTES-1:0]      rd_bvld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      seq_mem[slot]    <= seq_in_i;
      epoch_mem[slot]  <= epoch_in_i;
      status_mem[slot] <= status_in_i;
      size_mem[slot]   <= size_in_i;
      for (int b = 0; b < MAX_BYTES; b++) begin
        if (be[b]) data_mem[slot][b] <= data_in_i[8*b +: 8];
      end
    end
    if (rd_en) begin
      rd_seq_q    <= seq_mem[head_q];
      rd_epoch_q  <= epoch_mem[head_q];
      rd_status_q <= status_mem[head_q];
      rd_size_q   <= size_mem[head_q];
      rd_data_q   <= data_mem[head_q];
      rd_bvld_q   <= bvld_q[head_q];
    end
  end

  // Pending result of the executed command
  logic               res_ok_q, res_rdy_q, res_pop_q;
  logic [CntOutW-1:0] res_cnt_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.exec) begin
      res_ok_q  <= ok;
      res_rdy_q <= rdy_d;
      res_cnt_q <= CntOutW'(fill_d);
      res_pop_q <= rd_en;
    end
  end

  // Popped payload, unwritten bytes masked to zero
  logic [DataW-1:0] rd_data_m;

  for (genvar b = 0; b < DataW / 8; b++) begin : g_rdm
    if (b < MAX_BYTES) begin : g_byte
      assign rd_data_m[8*b +: 8] = rd_data_q[b] & {8{rd_bvld_q[b]}};
    end else begin : g_zero
      assign rd_data_m[8*b +: 8] = '0;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      ok_o         <= res_ok_q;
      is_ready_o   <= res_rdy_q;
      held_count_o <= res_cnt_q;
      rec_seq_o    <= res_pop_q ? rd_seq_q    : '0;
      rec_epoch_o  <= res_pop_q ? rd_epoch_q  : '0;
      rec_status_o <= res_pop_q ? rd_status_q : '0;
      rec_size_o   <= res_pop_q ? rd_size_q   : '0;
      rec_data_o   <= res_pop_q ? rd_data_m   : '0;
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(MAX_RECORDS))
    else $error("fill count exceeds store depth");

  a_ready_trig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rdy_q |-> trg_q)
    else $error("ready without trigger");

  a_trig_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trg_q |-> (arm_q && WinW'(fill_q) <= WinW'(cap_q)))
    else $error("triggered while disarmed or window overfilled");

endmodule

// ===== rtl/pre_post_trigger_capture_buffer.sv =====
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser cmd; tdata record words, terminal
// m_axis    out  m_axis_tvalid/m_axis_tready   tuser ok; tdata popped record, status
// cfg       in   cfg_valid_i/cfg_ready_o       cfg_index_i register, cfg_data_i value
//
// Each word passes through S_IDLE, which executes the command and issues the record
// store read, and then S_READ, which moves the result into the output register.
// A new word is accepted only after the previous result has moved into the output register.
// A result waiting on m_axis holds S_READ until the register frees.
// Reset clears flags, counters and the byte valid bits; no clearing pass.
module pre_post_trigger_capture_buffer #(
  parameter int unsigned MAX_RECORDS = pptcb_pkg::MaxRecordsDef,
  parameter int unsigned MAX_BYTES   = pptcb_pkg::MaxBytesDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input words
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // seq_in[31:0], epoch_in[63:32], status_in[95:64], size_in[99:96],
  // data_in[163:100], terminal[164], zero pad
  input  logic [pptcb_pkg::STdataW-1:0]  s_axis_tdata,
  // cmd[1:0]
  input  logic [1:0]                     s_axis_tuser,
  // result words
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // rec_seq[31:0], rec_epoch[63:32], rec_status[95:64], rec_size[99:96],
  // rec_data[163:100], is_ready[164], held_count[169:165], zero pad
  output logic [pptcb_pkg::MTdataW-1:0]  m_axis_tdata,
  // ok[0]
  output logic                           m_axis_tuser,
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pptcb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pptcb_pkg::CfgDataW-1:0] cfg_data_i
);
  import pptcb_pkg::*;

  ctl_t               ctl;
  logic [WordW-1:0]   rec_seq, rec_epoch, rec_status;
  logic [SizeW-1:0]   rec_size;
  logic [DataW-1:0]   rec_data;
  logic               is_ready;
  logic [CntOutW-1:0] held_count;

  assign cfg_ready_o = 1'b1;

  pptcb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .ctl_o       (ctl)
  );

  pptcb_dp #(
    .MAX_RECORDS (MAX_RECORDS),
    .MAX_BYTES   (MAX_BYTES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .cfg_we_i     (cfg_valid_i & cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd_e'(s_axis_tuser)),
    .seq_in_i     (s_axis_tdata[31:0]),
    .epoch_in_i   (s_axis_tdata[63:32]),
    .status_in_i  (s_axis_tdata[95:64]),
    .size_in_i    (s_axis_tdata[99:96]),
    .data_in_i    (s_axis_tdata[163:100]),
    .terminal_i   (s_axis_tdata[164]),
    .ok_o         (m_axis_tuser),
    .rec_seq_o    (rec_seq),
    .rec_epoch_o  (rec_epoch),
    .rec_status_o (rec_status),
    .rec_size_o   (rec_size),
    .rec_data_o   (rec_data),
    .is_ready_o   (is_ready),
    .held_count_o (held_count)
  );

  // pack the result word
  assign m_axis_tdata = {6'b0, held_count, is_ready, rec_data, rec_size,
                         rec_status, rec_epoch, rec_seq};

endmodule

// ===== bench/pre_post_trigger_capture_buffer_tb.sv =====
module pre_post_trigger_capture_buffer_tb;
  import pptcb_pkg::*;

  localparam int unsigned Depth         = MaxRecordsDef;
  localparam int unsigned Bytes         = MaxBytesDef;
  localparam int unsigned RandomItems   = 1750;
  localparam int unsigned QuietStretch  = 300;   // items with no gaps or stalls
  localparam int unsigned HoldCycles    = 300;   // long output stall
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned TailCycles    = 10;

  // one command word as the bench sees it
  typedef struct packed {
    logic        term;
    logic [63:0] data;
    logic [3:0]  size;
    logic [31:0] status;
    logic [31:0] epoch;
    logic [31:0] seq;
  } cap_item_t;

  // one result word, unpacked from tuser/tdata
  typedef struct packed {
    logic        ok;
    logic [31:0] seq;
    logic [31:0] epoch;
    logic [31:0] status;
    logic [3:0]  size;
    logic [63:0] data;
    logic        is_ready;
    logic [4:0]  held;
  } cap_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [STdataW-1:0]  s_axis_tdata;
  logic [1:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [MTdataW-1:0]  m_axis_tdata;
  logic                m_axis_tuser;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  pre_post_trigger_capture_buffer DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // bench control
  bit          gaps_on  = 1'b1;
  bit          stall_on = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned random_sent    = 0;
  cap_result_t pending_results[$];

  // capture buffer shadow: registers, ring and window state
  logic [7:0]  pre_reg  = '0;
  logic [7:0]  post_reg = '0;
  logic [31:0] seq_mem    [Depth];
  logic [31:0] epoch_mem  [Depth];
  logic [31:0] status_mem [Depth];
  logic [3:0]  size_mem   [Depth];
  logic [63:0] data_mem   [Depth];
  int unsigned head      = 0;
  int unsigned fill      = 0;
  int unsigned pre_lat   = 0;
  int unsigned win_cap   = 0;
  int unsigned post_owed = 0;
  bit          armed     = 1'b0;
  bit          trig      = 1'b0;
  bit          rdy       = 1'b0;

  // apply one command to the shadow and return the word the block must emit
  function automatic cap_result_t predict_capture(input cmd_e op, input cap_item_t it);
    cap_result_t r;
    int unsigned keep;
    int unsigned slot;
    logic [63:0] m;
    r = '0;
    r.ok = 1'b1;
    case (op)
      CMD_ARM: begin
        if (int'(pre_reg) + 1 + int'(post_reg) > Depth) begin
          r.ok = 1'b0;
        end else begin
          for (int i = 0; i < Depth; i++) begin
            seq_mem[i] = '0;
            epoch_mem[i] = '0;
            status_mem[i] = '0;
            size_mem[i] = '0;
            data_mem[i] = '0;
          end
          head = 0;
          fill = 0;
          pre_lat = pre_reg;
          win_cap = pre_reg + 1 + post_reg;
          post_owed = post_reg;
          armed = 1'b1;
          trig = 1'b0;
          rdy = 1'b0;
        end
      end
      CMD_PUSH: begin
        keep = trig ? win_cap : pre_lat + 1;
        if (!armed || rdy || it.size > Bytes) begin
          r.ok = 1'b0;
        end else if (fill >= keep && (trig || fill == 0)) begin
          r.ok = 1'b0;
        end else begin
          // pre-trigger: drop the oldest record to make room
          if (fill >= keep) begin
            head = (head + 1) % Depth;
            fill--;
          end
          slot = (head + fill) % Depth;
          seq_mem[slot] = it.seq;
          epoch_mem[slot] = it.epoch;
          status_mem[slot] = it.status;
          size_mem[slot] = it.size;
          m = (it.size >= Bytes) ? '1 : ((64'd1 << (8 * it.size)) - 64'd1);
          data_mem[slot] = (data_mem[slot] & ~m) | (it.data & m);
          fill++;
          if (trig && post_owed != 0) begin
            post_owed--;
            if (post_owed == 0) rdy = 1'b1;
          end
        end
      end
      CMD_TRIG: begin
        if (armed && !trig) begin
          trig = 1'b1;
          if (it.term || post_owed == 0) rdy = 1'b1;
        end
      end
      default: begin
        if (!rdy || fill == 0) begin
          r.ok = 1'b0;
        end else begin
          r.seq = seq_mem[head];
          r.epoch = epoch_mem[head];
          r.status = status_mem[head];
          r.size = size_mem[head];
          r.data = data_mem[head];
          head = (head + 1) % Depth;
          fill--;
          // emptied store disarms
          if (fill == 0) begin
            armed = 1'b0;
            trig = 1'b0;
            rdy = 1'b0;
          end
        end
      end
    endcase
    r.is_ready = rdy;
    r.held = fill[4:0];
    return r;
  endfunction

  function automatic cap_item_t rand_item();
    cap_item_t it;
    it.seq = $urandom;
    it.epoch = $urandom;
    it.status = $urandom;
    it.data = {$urandom, $urandom};
    it.term = ($urandom_range(0, 3) == 0);
    // mostly legal payload sizes, some oversized
    it.size = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(0, Bytes));
    return it;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < 40)
      $display("mismatch in %s at %0t: got %h, expected %h", what, $time, got, want);
    mismatch_count++;
  endtask

  // send one command word; entered and left at a falling edge
  task automatic send_cmd(input cmd_e op, input cap_item_t it);
    while (gaps_on && $urandom_range(0, 99) < 24) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {3'b000, it.term, it.data, it.size, it.status, it.epoch, it.seq};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(predict_capture(op, it));
    @(negedge clk_i);
  endtask

  // random phase: sometimes slip in an unrelated command first
  task automatic send_with_noise(input cmd_e op, input cap_item_t it);
    if ($urandom_range(0, 11) == 0) begin
      send_cmd(cmd_e'($urandom_range(0, 3)), rand_item());
      random_sent++;
    end
    send_cmd(op, it);
    random_sent++;
  endtask

  // let every pending result come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // write both window registers; block is idle here
  task automatic set_window(input logic [7:0] pre, input logic [7:0] post);
    for (int r = 0; r < 2; r++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= (r == 0) ? CfgPreCount : CfgPostCount;
      cfg_data_i  <= (r == 0) ? pre : post;
      do @(posedge clk_i); while (!cfg_ready_o);
      if (r == 0) pre_reg = pre;
      else post_reg = post;
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // --- directed tests ---

  // nothing armed yet: push and pop refused, trigger ignored
  task automatic test_unarmed_commands();
    send_cmd(CMD_PUSH, rand_item());
    send_cmd(CMD_TRIG, '1);
    send_cmd(CMD_POP, rand_item());
    drain();
  endtask

  // window must fit in the store
  task automatic test_arm_bounds();
    set_window(8'd255, 8'd255);
    send_cmd(CMD_ARM, '0);
    drain();
    set_window(8'd8, 8'd8);
    send_cmd(CMD_ARM, '0);
    drain();
    set_window(8'd0, 8'd15);
    send_cmd(CMD_ARM, '0);
    drain();
  endtask

  // full capture with pre 1 / post 2: drop oldest, partial payloads, readout
  task automatic test_window_cycle();
    cap_item_t it;
    set_window(8'd1, 8'd2);
    send_cmd(CMD_ARM, '0);
    send_cmd(CMD_PUSH, '0);
    it = '1;
    it.size = 4'd8;
    send_cmd(CMD_PUSH, it);
    it = rand_item();
    it.size = 4'd3;
    send_cmd(CMD_PUSH, it);
    it.size = 4'd9;
    send_cmd(CMD_PUSH, it);
    send_cmd(CMD_PUSH, '1);
    it.term = 1'b0;
    send_cmd(CMD_TRIG, it);
    send_cmd(CMD_TRIG, '1);
    send_cmd(CMD_POP, '0);
    send_cmd(CMD_PUSH, '0);
    it = rand_item();
    it.size = 4'd5;
    send_cmd(CMD_PUSH, it);
    send_cmd(CMD_PUSH, rand_item());
    repeat (5) send_cmd(CMD_POP, rand_item());
    drain();
  endtask

  // terminal trigger on an empty store, then re-arm while armed
  task automatic test_terminal_trigger();
    set_window(8'd0, 8'd3);
    send_cmd(CMD_ARM, '0);
    send_cmd(CMD_TRIG, '1);
    send_cmd(CMD_POP, '0);
    send_cmd(CMD_PUSH, '0);
    send_cmd(CMD_ARM, '0);
    drain();
  endtask

  // no post records owed: trigger alone makes the capture ready
  task automatic test_post_free_trigger();
    set_window(8'd15, 8'd0);
    send_cmd(CMD_ARM, '0);
    send_cmd(CMD_PUSH, rand_item());
    send_cmd(CMD_TRIG, '0);
    send_cmd(CMD_POP, '0);
    drain();
  endtask

  // long output stall while words keep coming
  task automatic test_output_stall();
    cap_item_t it;
    set_window(8'd3, 8'd4);
    hold_req = 1'b1;
    send_cmd(CMD_ARM, '0);
    repeat (6) send_cmd(CMD_PUSH, rand_item());
    it = rand_item();
    it.term = 1'b0;
    send_cmd(CMD_TRIG, it);
    repeat (5) send_cmd(CMD_PUSH, rand_item());
    repeat (9) send_cmd(CMD_POP, rand_item());
    drain();
  endtask

  // random captures with random content and window settings, some too large, with noise commands
  task automatic test_random_captures();
    logic [7:0]  pre;
    logic [7:0]  post;
    int unsigned n;
    int unsigned pre_span;
    cap_item_t   it;
    gaps_on = 1'b0;
    stall_on = 1'b0;
    while (random_sent < RandomItems) begin
      if (random_sent >= QuietStretch) begin
        gaps_on = 1'b1;
        stall_on = 1'b1;
      end
      case ($urandom_range(0, 7))
        0: begin
          pre = 8'($urandom_range(0, 255));
          post = 8'($urandom_range(0, 255));
        end
        1: begin
          pre = $urandom_range(0, 1) ? 8'd15 : 8'd0;
          post = 8'd15 - pre;
        end
        default: begin
          pre = 8'($urandom_range(0, 15));
          post = 8'($urandom_range(0, 15 - pre));
        end
      endcase
      set_window(pre, post);
      pre_span = (pre > 15) ? 4 : pre;
      repeat ($urandom_range(1, 3)) begin
        send_with_noise(CMD_ARM, rand_item());
        n = $urandom_range(0, pre_span + (($urandom_range(0, 3) == 0) ? 20 : 2));
        repeat (n) send_with_noise(CMD_PUSH, rand_item());
        send_with_noise(CMD_TRIG, rand_item());
        n = ((post > 15) ? 4 : post) + $urandom_range(0, 2);
        repeat (n) send_with_noise(CMD_PUSH, rand_item());
        repeat (fill + $urandom_range(0, 2)) send_with_noise(CMD_POP, rand_item());
      end
      drain();
    end
  endtask

  // result receiver with random stalls and one requested long hold
  initial begin : receiver
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      m_axis_tready <= !(stall_on && $urandom_range(0, 99) < 24);
    end
  end

  // compare each result word with the oldest prediction
  always @(posedge clk_i) begin
    cap_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result word", m_axis_tdata[63:0], '0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.ok)
          report_mismatch("ok", m_axis_tuser, want.ok);
        if (m_axis_tdata[31:0] !== want.seq)
          report_mismatch("rec_seq", m_axis_tdata[31:0], want.seq);
        if (m_axis_tdata[63:32] !== want.epoch)
          report_mismatch("rec_epoch", m_axis_tdata[63:32], want.epoch);
        if (m_axis_tdata[95:64] !== want.status)
          report_mismatch("rec_status", m_axis_tdata[95:64], want.status);
        if (m_axis_tdata[99:96] !== want.size)
          report_mismatch("rec_size", m_axis_tdata[99:96], want.size);
        if (m_axis_tdata[163:100] !== want.data)
          report_mismatch("rec_data", m_axis_tdata[163:100], want.data);
        if (m_axis_tdata[164] !== want.is_ready)
          report_mismatch("is_ready", m_axis_tdata[164], want.is_ready);
        if (m_axis_tdata[169:165] !== want.held)
          report_mismatch("held_count", m_axis_tdata[169:165], want.held);
      end
    end
  end

  // watchdog: too long without any word moving on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : main_seq
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = CMD_ARM;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgPreCount;
    cfg_data_i = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_unarmed_commands();
    test_arm_bounds();
    test_window_cycle();
    test_terminal_trigger();
    test_post_free_trigger();
    test_output_stall();
    test_random_captures();
    drain();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
